FILE: rtl/core/epxf_pkg.sv
// Shared types and constants of the equal-power crossfade core.
package epxf_pkg;

    localparam int SAMPLE_W           = 24;
    localparam int LEN_W              = 11;
    localparam int DEFAULT_MAX_LENGTH = 1024;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd256;

    // Q0.32 ratio may reach exactly 1.0, so one extra integer bit
    localparam int RATIO_W   = 33;
    localparam int FRAC_W    = 32;
    localparam int GAIN_W    = 17;
    localparam int ROOT_W    = 34;
    localparam int ALU_W     = 35;
    localparam int ACC_W     = 42;
    localparam int ROUND_SH  = 16;
    localparam int DIV_STEPS = 33;
    localparam int CNT_W     = 6;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 42'sd32768;
    localparam logic signed [ACC_W-1:0] SAT_MAX    = 42'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -42'sd8388608;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT_LOAD,
        ST_ROOT_OUT,
        ST_ROOT_IN,
        ST_MUL_OUT,
        ST_MUL_IN,
        ST_SUM,
        ST_EMIT
    } epxf_state_t;

endpackage

FILE: rtl/core/equal_power_crossfade_core.sv
// Equal-power crossfade core: sqrt-law gains from a shared subtract/compare unit.
//
// Usage
//   Input channel (in_valid/in_ready) carries one pair of signed 24-bit samples
//   per transaction: outgoing_sample fades out, incoming_sample fades in.
//   Output channel (out_valid/out_ready) returns one mixed 24-bit sample per
//   input transaction, with block_end set on the last sample of a fade block.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes fade_length; write it
//   only while no transaction is in flight. cfg_ready is always high.
//   Sequence: an accepted item runs 33 divide steps, a root load step,
//   two 17-step square roots, two multiply steps, one sum and one emit step
//   through one shared 35-bit subtract/compare unit and one 24x18 multiplier.
//   The result is registered in the emit step; a new item is taken only once
//   the previous one has left the emit step.
//   Stall: the output register holds a result until taken; a finished item
//   waits in the emit step while that register is still full, and in_ready
//   stays low until the result moves into it.
//   Reset: fade_length returns to 256, position to 0, all channels go idle.
module equal_power_crossfade_core
    import epxf_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [LEN_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] outgoing_sample,
    input  logic signed [SAMPLE_W-1:0] incoming_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_sample,
    output logic                       block_end
);

    localparam int POS_W = $clog2(MAX_LENGTH);

    // Control state
    epxf_state_t      state_reg, state_next;
    logic [LEN_W-1:0] fade_length_reg, fade_length_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic signed [SAMPLE_W-1:0] out_smp_reg, out_smp_next;
    logic signed [SAMPLE_W-1:0] in_smp_reg, in_smp_next;
    logic [POS_W-1:0]           m_reg, m_next;
    logic [POS_W-1:0]           i_reg, i_next;
    logic                       last_reg, last_next;
    logic [POS_W-1:0]           rem_reg, rem_next;
    logic [RATIO_W-1:0]         q_reg, q_next;
    logic [RATIO_W-1:0]         x_reg, x_next;
    logic [ROOT_W-1:0]          res_reg, res_next;
    logic [RATIO_W-1:0]         bit_reg, bit_next;
    logic [GAIN_W-1:0]          g_out_reg, g_out_next;
    logic [GAIN_W-1:0]          g_in_reg, g_in_next;
    logic signed [ACC_W-1:0]    prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] mixed_reg, mixed_next;
    logic                       block_end_reg, block_end_next;

    // Shared subtract/compare unit
    logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
    logic             alu_ge;

    // Shared multiplier
    logic signed [SAMPLE_W-1:0] mul_a;
    logic [GAIN_W-1:0]          mul_g;
    logic signed [ACC_W-1:0]    mul_prod;

    // Block-length decode
    logic [31:0]        len32, n32, m32, pos32;
    logic               pos_last;
    logic [RATIO_W-1:0] ratio_out;
    logic [ROOT_W-1:0]  root_step;
    logic signed [ACC_W-1:0] rounded;
    logic [RATIO_W-1:0] bit_init;

    assign bit_init  = {1'b1, {FRAC_W{1'b0}}};
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign mixed_sample = mixed_reg;
    assign block_end    = block_end_reg;

    // Clamp the length to 2..MAX_LENGTH and find the effective position
    always_comb
    begin
        len32 = 32'(fade_length_reg);
        n32   = len32;
        if (len32 < 32'd2)
        begin
            n32 = 32'd2;
        end
        if (len32 > 32'(MAX_LENGTH))
        begin
            n32 = 32'(MAX_LENGTH);
        end
        m32      = n32 - 32'd1;
        pos32    = 32'(position_reg);
        pos_last = (pos32 >= m32);
    end

    assign alu_diff = alu_a - alu_b;
    assign alu_ge   = (alu_a >= alu_b);

    assign mul_prod = ACC_W'(mul_a) * ACC_W'($signed({1'b0, mul_g}));

    // Outgoing ratio from the incoming quotient: 2^32 - ceil(i*2^32/m)
    assign ratio_out = RATIO_W'(({1'b1, {FRAC_W{1'b0}}}) - ROOT_W'(q_reg)
                                - ROOT_W'(rem_reg != '0));

    assign root_step = ROOT_W'(alu_ge ? ((res_reg >> 1) + ROOT_W'(bit_reg))
                                      : (res_reg >> 1));

    assign rounded = (acc_reg + ROUND_HALF) >>> ROUND_SH;

    always_comb
    begin
        state_next       = state_reg;
        fade_length_next = fade_length_reg;
        position_next    = position_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        out_smp_next     = out_smp_reg;
        in_smp_next      = in_smp_reg;
        m_next           = m_reg;
        i_next           = i_reg;
        last_next        = last_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        x_next           = x_reg;
        res_next         = res_reg;
        bit_next         = bit_reg;
        g_out_next       = g_out_reg;
        g_in_next        = g_in_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        mixed_next       = mixed_reg;
        block_end_next   = block_end_reg;
        alu_a            = '0;
        alu_b            = '0;
        mul_a            = out_smp_reg;
        mul_g            = g_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            fade_length_next = cfg_data;
        end

        // Drop the output once taken; the emit step may refill it below
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    out_smp_next  = outgoing_sample;
                    in_smp_next   = incoming_sample;
                    m_next        = POS_W'(m32);
                    last_next     = pos_last;
                    i_next        = pos_last ? POS_W'(m32) : position_reg;
                    position_next = pos_last ? '0 : POS_W'(pos32 + 32'd1);
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end

            // Restoring divide of i*2^32 by m, one quotient bit per step
            ST_DIV:
            begin
                alu_a    = (cnt_reg == '0) ? ALU_W'(i_reg) : ALU_W'({rem_reg, 1'b0});
                alu_b    = ALU_W'(m_reg);
                rem_next = POS_W'(alu_ge ? alu_diff : alu_a);
                q_next   = {q_reg[RATIO_W-2:0], alu_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_ROOT_LOAD;
                end
            end

            ST_ROOT_LOAD:
            begin
                x_next     = ratio_out;
                res_next   = '0;
                bit_next   = bit_init;
                state_next = ST_ROOT_OUT;
            end

            // Digit-by-digit integer square root, two bits of x per step
            ST_ROOT_OUT,
            ST_ROOT_IN:
            begin
                alu_a    = ALU_W'(x_reg);
                alu_b    = ALU_W'(res_reg) + ALU_W'(bit_reg);
                x_next   = alu_ge ? RATIO_W'(alu_diff) : x_reg;
                res_next = root_step;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    if (state_reg == ST_ROOT_OUT)
                    begin
                        g_out_next = GAIN_W'(root_step);
                        x_next     = q_reg;
                        res_next   = '0;
                        bit_next   = bit_init;
                        state_next = ST_ROOT_IN;
                    end
                    else
                    begin
                        g_in_next  = GAIN_W'(root_step);
                        state_next = ST_MUL_OUT;
                    end
                end
            end

            ST_MUL_OUT:
            begin
                mul_a      = out_smp_reg;
                mul_g      = g_out_reg;
                prod_next  = mul_prod;
                state_next = ST_MUL_IN;
            end

            ST_MUL_IN:
            begin
                mul_a      = in_smp_reg;
                mul_g      = g_in_reg;
                acc_next   = prod_reg;
                prod_next  = mul_prod;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_EMIT;
            end

            // Round half up, saturate, and hold until the output register frees
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (rounded > SAT_MAX)
                    begin
                        mixed_next = SAMPLE_W'(SAT_MAX);
                    end
                    else if (rounded < SAT_MIN)
                    begin
                        mixed_next = SAMPLE_W'(SAT_MIN);
                    end
                    else
                    begin
                        mixed_next = SAMPLE_W'(rounded);
                    end
                    block_end_next = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fade_length_reg <= LEN_RESET;
            position_reg    <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fade_length_reg <= fade_length_next;
            position_reg    <= position_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_smp_reg   <= out_smp_next;
        in_smp_reg    <= in_smp_next;
        m_reg         <= m_next;
        i_reg         <= i_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        x_reg         <= x_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        g_out_reg     <= g_out_next;
        g_in_reg      <= g_in_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        mixed_reg     <= mixed_next;
        block_end_reg <= block_end_next;
    end

endmodule
